// ===== sv/bole_pkg.sv =====
// Shared constants, operation and status codes, and types for the ordered list engine.
package bole_pkg;

  localparam int Capacity = 16;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int KindW    = 3;
  localparam int PosW     = 16;
  localparam int ValW     = 32;
  localparam int StW      = 2;
  localparam int LenW     = 5;

  localparam logic [KindW-1:0] KIND_FRONT  = 3'd0;
  localparam logic [KindW-1:0] KIND_BACK   = 3'd1;
  localparam logic [KindW-1:0] KIND_POS    = 3'd2;
  localparam logic [KindW-1:0] KIND_DELETE = 3'd3;
  localparam logic [KindW-1:0] KIND_SEARCH = 3'd4;

  localparam logic [StW-1:0] ST_OK       = 2'd0;
  localparam logic [StW-1:0] ST_BADPOS   = 2'd1;
  localparam logic [StW-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [StW-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [ValW-1:0] wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [StW-1:0] status;
    logic           found;
  } res_t;

endpackage

// ===== sv/bole_in_if.sv =====
// Request channel: operation kind, insert position and value.
interface bole_in_if;
  import bole_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KindW-1:0]       kind;
  logic [PosW-1:0]        position;
  logic signed [ValW-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

// ===== sv/bole_out_if.sv =====
// Result channel: status, found flag and list length.
interface bole_out_if;
  import bole_pkg::*;

  logic             valid;
  logic             ready;
  logic [StW-1:0]   status;
  logic             found;
  logic [LenW-1:0]  length;

  modport source (output valid, output status, output found, output length, input ready);
  modport sink   (input valid, input status, input found, input length, output ready);
endinterface

// ===== sv/bole_mem.sv =====
// Entry store: one write port and one registered read port.
module bole_mem (
  input  logic                         clk_i,
  input  bole_pkg::mem_req_t           req_i,
  output logic [bole_pkg::ValW-1:0]    rdata_o
);
  import bole_pkg::*;

  logic [ValW-1:0] mem_q [Capacity];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

// ===== sv/bole_seq.sv =====
// Sequencer: walks and shifts the entry store one entry per step, keeps the count.
module bole_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bole_pkg::KindW-1:0]   kind_i,
  input  logic [bole_pkg::PosW-1:0]    position_i,
  input  logic [bole_pkg::ValW-1:0]    value_i,
  input  logic [bole_pkg::ValW-1:0]    rdata_i,
  input  logic                         take_i,
  output logic                         idle_o,
  output logic                         done_o,
  output bole_pkg::res_t               res_o,
  output logic [bole_pkg::CntW-1:0]    count_o,
  output bole_pkg::mem_req_t           mem_o
);
  import bole_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FIND_RD  = 4'd1;
  localparam logic [3:0] S_FIND_CMP = 4'd2;
  localparam logic [3:0] S_SHL_RD   = 4'd3;
  localparam logic [3:0] S_SHL_WR   = 4'd4;
  localparam logic [3:0] S_SHR_RD   = 4'd5;
  localparam logic [3:0] S_SHR_WR   = 4'd6;
  localparam logic [3:0] S_PUT      = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [KindW-1:0] kind_q, kind_d;
  logic [ValW-1:0]  val_q, val_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  at_q, at_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  res_t             res_q, res_d;

  logic [CntW:0]    idx_p1, idx_p2, cnt_p1;
  logic [CntW-1:0]  place_at;
  logic             place_go;
  logic             pos_bad;

  assign idx_p1 = {1'b0, idx_q} + (CntW + 1)'(1);
  assign idx_p2 = {1'b0, idx_q} + (CntW + 1)'(2);
  assign cnt_p1 = {1'b0, cnt_q} + (CntW + 1)'(1);
  assign pos_bad = (position_i == '0) ||
                   ({{(CntW + 1){1'b0}}, position_i} > {{PosW{1'b0}}, cnt_p1});

  always_comb begin
    place_go = 1'b0;
    place_at = '0;
    case (kind_i)
      KIND_FRONT: begin
        place_go = 1'b1;
        place_at = '0;
      end
      KIND_BACK: begin
        place_go = 1'b1;
        place_at = cnt_q;
      end
      KIND_POS: begin
        place_go = !pos_bad;
        place_at = CntW'(position_i - PosW'(1));
      end
      default: begin
        place_go = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    val_d   = val_q;
    idx_d   = idx_q;
    at_d    = at_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    mem_o   = '{we: 1'b0, waddr: idx_q[IdxW-1:0], wdata: rdata_i, raddr: idx_q[IdxW-1:0]};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          kind_d  = kind_i;
          val_d   = value_i;
          idx_d   = '0;
          res_d   = '{status: ST_OK, found: 1'b0};
          state_d = S_DONE;
          if (kind_i == KIND_FRONT || kind_i == KIND_BACK || kind_i == KIND_POS) begin
            if (!place_go) begin
              res_d.status = ST_BADPOS;
            end else if ({1'b0, cnt_q} >= (CntW + 1)'(Capacity)) begin
              res_d.status = ST_FULL;
            end else begin
              at_d    = place_at;
              idx_d   = cnt_q;
              state_d = (cnt_q > place_at) ? S_SHR_RD : S_PUT;
            end
          end else if (kind_i == KIND_DELETE || kind_i == KIND_SEARCH) begin
            if (cnt_q == '0) begin
              res_d.status = (kind_i == KIND_DELETE) ? ST_NOTFOUND : ST_OK;
            end else begin
              state_d = S_FIND_RD;
            end
          end
        end
      end
      S_FIND_RD: begin
        state_d = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (rdata_i == val_q) begin
          res_d.found = 1'b1;
          if (kind_q == KIND_DELETE && idx_p1 < {1'b0, cnt_q}) begin
            state_d = S_SHL_RD;
          end else begin
            if (kind_q == KIND_DELETE) begin
              cnt_d = cnt_q - CntW'(1);
            end
            state_d = S_DONE;
          end
        end else if (idx_p1 == {1'b0, cnt_q}) begin
          res_d.status = (kind_q == KIND_DELETE) ? ST_NOTFOUND : ST_OK;
          state_d      = S_DONE;
        end else begin
          idx_d   = idx_p1[CntW-1:0];
          state_d = S_FIND_RD;
        end
      end
      S_SHL_RD: begin
        mem_o.raddr = idx_p1[IdxW-1:0];
        state_d     = S_SHL_WR;
      end
      S_SHL_WR: begin
        mem_o.we = 1'b1;
        idx_d    = idx_p1[CntW-1:0];
        if (idx_p2 < {1'b0, cnt_q}) begin
          state_d = S_SHL_RD;
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = S_DONE;
        end
      end
      S_SHR_RD: begin
        mem_o.raddr = IdxW'(idx_q - CntW'(1));
        state_d     = S_SHR_WR;
      end
      S_SHR_WR: begin
        mem_o.we = 1'b1;
        idx_d    = idx_q - CntW'(1);
        state_d  = ((idx_q - CntW'(1)) > at_q) ? S_SHR_RD : S_PUT;
      end
      S_PUT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = at_q[IdxW-1:0];
        mem_o.wdata = val_q;
        cnt_d       = cnt_p1[CntW-1:0];
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    val_q  <= val_d;
    idx_q  <= idx_d;
    at_q   <= at_d;
    res_q  <= res_d;
  end

  assign idle_o  = (state_q == S_IDLE);
  assign done_o  = (state_q == S_DONE);
  assign res_o   = res_q;
  assign count_o = cnt_q;

endmodule

// ===== sv/bounded_ordered_list_engine_top.sv =====
// Top level of the bounded ordered list engine.
//
// Keeps an ordered list of up to Capacity signed 32-bit values. Each request
// transfer on in_i carries kind, position and value: insert front, insert back,
// insert at a 1-based position, delete the first matching value, or search.
// Each request yields one result transfer on out_o with status, found, length.
// The engine takes one item at a time through an entry store with registered read.
// A rejected or trivial request goes straight to its result. An insert moves
// each entry behind the insert position up by one, a read and then a write per
// entry, and then writes the new value; a search or delete reads and compares
// entries in turn, and a delete then moves each entry behind the match down.
// in_i.ready is high only while the sequencer is idle; it rises as the result
// is registered. A result sits in an output register, so a new request is
// taken while an earlier result waits; a stalled receiver holds the result
// and, once the next item is finished, holds the sequencer too.
// Reset empties the list at once; no clearing pass is needed.
module bounded_ordered_list_engine_top (
  input logic        clk_i,
  input logic        rst_ni,
  bole_in_if.sink    in_i,
  bole_out_if.source out_o
);
  import bole_pkg::*;

  logic            seq_idle, seq_done, take;
  res_t            seq_res;
  logic [CntW-1:0] seq_cnt;
  mem_req_t        mem_req;
  logic [ValW-1:0] mem_rdata;

  logic            out_valid_q, out_valid_d;
  res_t            out_res_q;
  logic [LenW-1:0] out_len_q;

  assign in_i.ready = seq_idle;
  assign take       = seq_done && (!out_valid_q || out_o.ready);

  bole_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_i.valid && seq_idle),
    .kind_i     (in_i.kind),
    .position_i (in_i.position),
    .value_i    (in_i.value),
    .rdata_i    (mem_rdata),
    .take_i     (take),
    .idle_o     (seq_idle),
    .done_o     (seq_done),
    .res_o      (seq_res),
    .count_o    (seq_cnt),
    .mem_o      (mem_req)
  );

  bole_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_res_q <= seq_res;
      out_len_q <= LenW'(seq_cnt);
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_res_q.status;
  assign out_o.found  = out_res_q.found;
  assign out_o.length = out_len_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, seq_cnt} <= (CntW + 1)'(Capacity))
    else $error("entry count above capacity");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("sequencer still idle after a request transfer");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && seq_res.status == ST_FULL |-> {1'b0, seq_cnt} == (CntW + 1)'(Capacity))
    else $error("full status on a list that is not full");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && seq_res.found |-> seq_res.status == ST_OK)
    else $error("found flag with an error status");

endmodule
